[src/md5de_pkg.sv]
// Package with the MD5 constants, round helper functions and shared types.
`timescale 1ns / 1ps
`default_nettype none

package md5de_pkg;

  typedef logic [31:0]  word_t;
  typedef logic [3:0]   slot_t;
  typedef logic [5:0]   round_t;
  typedef logic [63:0]  len_t;
  typedef logic [127:0] chain_t;

  localparam word_t IV_A     = 32'h67452301;
  localparam word_t IV_B     = 32'hefcdab89;
  localparam word_t IV_C     = 32'h98badcfe;
  localparam word_t IV_D     = 32'h10325476;
  localparam word_t PAD_WORD = 32'h00000080;

  localparam slot_t SLOT_LEN_LO = 4'd14;
  localparam slot_t SLOT_LEN_HI = 4'd15;
  localparam slot_t SLOT_LAST_FIT = 4'd13;

  localparam word_t SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Control from the sequencer to the compression unit.
  typedef struct packed {
    logic  start;
    logic  clear_iv;
    logic  wr_en;
    slot_t wr_addr;
    word_t wr_data;
  } cu_ctrl_t;

  // Status back from the compression unit: chain is {D, C, B, A}.
  typedef struct packed {
    logic   done;
    chain_t chain;
  } cu_stat_t;

  // Message word used by a given round.
  function automatic slot_t msg_index(input round_t r);
    slot_t lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    return lo;
      2'd1:    return (lo << 2) + lo + 4'd1;
      2'd2:    return (lo << 1) + lo + 4'd5;
      default: return (lo << 3) - lo;
    endcase
  endfunction

  // Boolean mixing function of the round group.
  function automatic word_t mix_fn(input round_t r, input word_t b, input word_t c,
                                   input word_t d);
    case (r[5:4])
      2'd0:    return (b & c) | (~b & d);
      2'd1:    return (d & b) | (~d & c);
      2'd2:    return b ^ c ^ d;
      default: return c ^ (b | ~d);
    endcase
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

`default_nettype wire

[src/md5de_msg_if.sv]
// Message word channel: valid/ready handshake with the word payload.
`timescale 1ns / 1ps
`default_nettype none

interface md5de_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

`default_nettype wire

[src/md5de_dig_if.sv]
// Digest channel: valid/ready handshake with one 64-bit digest half.
`timescale 1ns / 1ps
`default_nettype none

interface md5de_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic        final_part;

  modport source (output valid, digest_part, final_part, input ready);
  modport sink   (input valid, digest_part, final_part, output ready);
endinterface

`default_nettype wire

[src/md5de_comp_unit.sv]
// Block store memory, chaining values and the one-round-per-cycle MD5 datapath.
`timescale 1ns / 1ps
`default_nettype none

module md5de_comp_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire md5de_pkg::cu_ctrl_t ctrl,
  output md5de_pkg::cu_stat_t      stat
);
  import md5de_pkg::*;

  typedef enum logic [2:0] {
    CU_IDLE = 3'b001,
    CU_RUN  = 3'b010,
    CU_ADD  = 3'b100
  } cu_state_t;

  cu_state_t   state;
  word_t       mem [16];
  word_t       rdata;
  slot_t       rd_addr;
  logic [6:0]  rnd_cnt;
  round_t      rnd;
  word_t       a, b, c, d;
  word_t       ch_a, ch_b, ch_c, ch_d;
  word_t       f_sum;
  word_t       b_next;

  // The read address runs one round ahead of the datapath.
  assign rd_addr = msg_index(rnd_cnt[5:0]);
  assign rnd     = 6'(rnd_cnt - 7'd1);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    f_sum  = mix_fn(rnd, b, c, d) + a + SINE_K[rnd] + rdata;
    b_next = b + rotl(f_sum, ROT_AMT[{rnd[5:4], rnd[1:0]}]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= CU_IDLE;
      rnd_cnt <= '0;
      ch_a    <= IV_A;
      ch_b    <= IV_B;
      ch_c    <= IV_C;
      ch_d    <= IV_D;
    end else begin
      unique case (state)
        CU_IDLE: begin
          if (ctrl.clear_iv) begin
            ch_a <= IV_A;
            ch_b <= IV_B;
            ch_c <= IV_C;
            ch_d <= IV_D;
          end
          if (ctrl.start) begin
            a       <= ch_a;
            b       <= ch_b;
            c       <= ch_c;
            d       <= ch_d;
            rnd_cnt <= '0;
            state   <= CU_RUN;
          end
        end
        CU_RUN: begin
          if (rnd_cnt != 7'd0) begin
            a <= d;
            d <= c;
            c <= b;
            b <= b_next;
          end
          if (rnd_cnt == 7'd64) begin
            state <= CU_ADD;
          end
          rnd_cnt <= rnd_cnt + 7'd1;
        end
        CU_ADD: begin
          ch_a  <= ch_a + a;
          ch_b  <= ch_b + b;
          ch_c  <= ch_c + c;
          ch_d  <= ch_d + d;
          state <= CU_IDLE;
        end
        default: state <= CU_IDLE;
      endcase
    end
  end

  assign stat.done  = (state == CU_ADD);
  assign stat.chain = {ch_d, ch_c, ch_b, ch_a};

endmodule

`default_nettype wire

[src/md5_digest_engine_top.sv]
// Top level of the MD5 digest engine: word intake, padding sequencer and digest output.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Role  | Payload                              | Request
// --------+-------+--------------------------------------+-------------------------------
// msg     | sink  | data_word[31:0], byte_count, last    | one message word (LE bytes)
// digest  | source| digest_part[63:0], final_part        | A|B half first, then C|D half
//
// Each message word is written into the 16-entry block store when it is taken.
// The word that fills the block starts the compression unit, which primes its read,
// runs the 64 rounds at one round per cycle and then updates the chaining values. After
// the last word the sequencer writes the padding and length one word per cycle (up
// to 16 more, plus a second block if the length does not fit). Reset is synchronous;
// the block store needs no clearing.
// The digest sits in its own register, so a new message may start while it waits.

module md5_digest_engine_top (
  input wire logic clk,
  input wire logic rst,
  md5de_msg_if.sink   msg,
  md5de_dig_if.source digest
);
  import md5de_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_COMP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t     state;
  slot_t      slot;
  len_t       bit_total;
  logic       msg_end;      // padding of the current message is under way
  logic       pad_pending;  // the 0x80 marker still has to be written
  logic       len_ok;       // the current block has room for the length
  logic       final_blk;    // the block being compressed holds the length
  logic       out_valid;
  logic       out_second;
  chain_t     dig;

  cu_ctrl_t   cu_ctrl;
  cu_stat_t   cu_stat;

  logic       accept;
  logic [2:0] cnt_sat;
  word_t      tail_word;
  word_t      wr_word;
  logic       wr_en;
  logic       blk_full;

  md5de_comp_unit u_comp (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cu_ctrl),
    .stat (cu_stat)
  );

  assign msg.ready = (state == ST_IDLE);
  assign accept    = msg.valid && msg.ready;

  // A count above four on the last word is taken as four.
  assign cnt_sat = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

  // Partial last word: keep the valid bytes and put the marker right after them.
  always_comb begin
    case (cnt_sat)
      3'd0:    tail_word = PAD_WORD;
      3'd1:    tail_word = {16'h0000, 8'h80, msg.data_word[7:0]};
      3'd2:    tail_word = {8'h00, 8'h80, msg.data_word[15:0]};
      3'd3:    tail_word = {8'h80, msg.data_word[23:0]};
      default: tail_word = msg.data_word;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_word = '0;
    if (state == ST_IDLE) begin
      wr_en   = accept;
      wr_word = (!msg.last_word || cnt_sat == 3'd4) ? msg.data_word : tail_word;
    end else if (state == ST_FILL) begin
      wr_en = 1'b1;
      if (pad_pending) begin
        wr_word = PAD_WORD;
      end else if (len_ok && slot == SLOT_LEN_LO) begin
        wr_word = bit_total[31:0];
      end else if (len_ok && slot == SLOT_LEN_HI) begin
        wr_word = bit_total[63:32];
      end
    end
  end

  assign blk_full = wr_en && (slot == SLOT_LEN_HI);

  assign cu_ctrl.start    = blk_full;
  assign cu_ctrl.clear_iv = (state == ST_EMIT) && !out_valid;
  assign cu_ctrl.wr_en    = wr_en;
  assign cu_ctrl.wr_addr  = slot;
  assign cu_ctrl.wr_data  = wr_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot        <= '0;
      bit_total   <= '0;
      msg_end     <= 1'b0;
      pad_pending <= 1'b0;
      len_ok      <= 1'b0;
      final_blk   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            slot <= slot + 4'd1;
            if (!msg.last_word) begin
              bit_total <= bit_total + 64'd32;
              msg_end   <= 1'b0;
              state     <= blk_full ? ST_COMP : ST_IDLE;
            end else begin
              bit_total   <= bit_total + (64'(cnt_sat) << 3);
              msg_end     <= 1'b1;
              pad_pending <= (cnt_sat == 3'd4);
              len_ok      <= (cnt_sat != 3'd4) && (slot <= SLOT_LAST_FIT);
              final_blk   <= 1'b0;
              state       <= blk_full ? ST_COMP : ST_FILL;
            end
          end
        end
        ST_FILL: begin
          slot <= slot + 4'd1;
          if (pad_pending) begin
            pad_pending <= 1'b0;
            len_ok      <= (slot <= SLOT_LAST_FIT);
          end
          if (blk_full) begin
            final_blk <= len_ok && !pad_pending;
            state     <= ST_COMP;
          end
        end
        ST_COMP: begin
          if (cu_stat.done) begin
            if (!msg_end) begin
              state <= ST_IDLE;
            end else if (final_blk) begin
              state <= ST_EMIT;
            end else begin
              // The length always fits into the block after a wrap.
              len_ok <= 1'b1;
              state  <= ST_FILL;
            end
          end
        end
        ST_EMIT: begin
          // Wait here until the previous digest has been taken.
          if (!out_valid) begin
            slot      <= '0;
            bit_total <= '0;
            msg_end   <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Digest register: two requests, A|B then C|D.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      out_second <= 1'b0;
    end else begin
      if (state == ST_EMIT && !out_valid) begin
        out_valid  <= 1'b1;
        out_second <= 1'b0;
      end else if (out_valid && digest.ready) begin
        if (!out_second) begin
          out_second <= 1'b1;
        end else begin
          out_valid  <= 1'b0;
          out_second <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && !out_valid) begin
      dig <= cu_stat.chain;
    end
  end

  assign digest.valid       = out_valid;
  assign digest.digest_part = out_second ? dig[127:64] : dig[63:0];
  assign digest.final_part  = out_second;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the MD5 digest engine: message words in, digest halves out.
`timescale 1ns / 1ps

module testbench;
  import md5de_pkg::word_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [2:0] FULL_WORD = 3'd4;
  localparam word_t PAD_BYTE = 32'h00000080;

  // Standard MD5 initial chaining values, in A, B, C, D order.
  localparam word_t START_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  // Per-round additive constants, floor(abs(sin(i + 1)) * 2^32).
  localparam word_t ROUND_ADD [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts: four per round group, repeating within the group.
  localparam int ROT_BY [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  typedef struct packed {
    logic [63:0] part;
    logic        second_half;
  } digest_rec_t;

  logic clk;
  logic rst;

  md5de_msg_if msg_ch ();
  md5de_dig_if dig_ch ();

  md5_digest_engine_top DUT (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  // Predictor state: chaining values, partly filled block, fill pointer and length.
  word_t       md5_chain [4];
  word_t       md5_block [16];
  logic [3:0]  fill_slot;
  logic [63:0] msg_bits;

  // Digest halves that the engine still owes, oldest first.
  digest_rec_t pending_digest [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  words_sent = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;

  // ---------------------------------------------------------------------------
  // Clock, and a cycle counter that ends a hung run.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d digest halves outstanding",
               $realtime, cycle_count, pending_digest.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor. One 64-round MD5 compression over the 16-word block.
  // ---------------------------------------------------------------------------
  function automatic void fold_block();
    word_t a, b, c, d, f, sum;
    int    g, sh;
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = f + a + ROUND_ADD[r] + md5_block[g];
      sh = ROT_BY[(r / 16) * 4 + (r % 4)];
      a = d;
      d = c;
      c = b;
      b = b + ((sum << sh) | (sum >> (32 - sh)));
    end
    md5_chain[0] = md5_chain[0] + a;
    md5_chain[1] = md5_chain[1] + b;
    md5_chain[2] = md5_chain[2] + c;
    md5_chain[3] = md5_chain[3] + d;
  endfunction

  // Store one word; the word that completes a block triggers a compression.
  function automatic void absorb_word(input word_t w);
    md5_block[fill_slot] = w;
    fill_slot = fill_slot + 4'd1;
    if (fill_slot == 4'd0) fold_block();
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 4; i++) md5_chain[i] = START_CHAIN[i];
    fill_slot = 4'd0;
    msg_bits = 64'd0;
  endfunction

  // Work out what one accepted request does to the digest state. A last request
  // finishes the padding and queues both digest halves.
  function automatic void predict_digest(input word_t data, input logic [2:0] count,
                                         input logic last);
    int          nbytes;
    word_t       pad, keep;
    digest_rec_t rec;
    if (!last) begin
      // A short count on a middle word is ignored: the word always carries four bytes.
      msg_bits = msg_bits + 64'd32;
      absorb_word(data);
      return;
    end
    nbytes = (count > FULL_WORD) ? 4 : int'(count);
    msg_bits = msg_bits + 64'(8 * nbytes);
    if (nbytes == 4) begin
      absorb_word(data);
      pad = PAD_BYTE;
    end else begin
      keep = (nbytes == 0) ? 32'd0 : (32'hffffffff >> (32 - 8 * nbytes));
      pad = (data & keep) | (PAD_BYTE << (8 * nbytes));
    end
    absorb_word(pad);
    // No room left for the two length words: zero-fill and start another block.
    if (fill_slot > 4'd14 || fill_slot == 4'd0) begin
      while (fill_slot != 4'd0) absorb_word(32'd0);
    end
    while (fill_slot < 4'd14) absorb_word(32'd0);
    absorb_word(msg_bits[31:0]);
    absorb_word(msg_bits[63:32]);
    rec.part = {md5_chain[1], md5_chain[0]};
    rec.second_half = 1'b0;
    pending_digest.push_back(rec);
    rec.part = {md5_chain[3], md5_chain[2]};
    rec.second_half = 1'b1;
    pending_digest.push_back(rec);
    restart_message();
  endfunction

  // ---------------------------------------------------------------------------
  // Digest side: random stall bursts on ready, and the result checker.
  // ---------------------------------------------------------------------------
  initial begin
    dig_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        dig_ch.ready = 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        dig_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_digest
    digest_rec_t want;
    if (!rst && dig_ch.valid && dig_ch.ready) begin
      if (pending_digest.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected digest half, expected none, actual %h final %b",
                 $realtime, dig_ch.digest_part, dig_ch.final_part);
      end else begin
        want = pending_digest.pop_front();
        if (dig_ch.digest_part !== want.part) begin
          fail_count++;
          $display("%0t: digest_part mismatch, expected %h actual %h",
                   $realtime, want.part, dig_ch.digest_part);
        end
        if (dig_ch.final_part !== want.second_half) begin
          fail_count++;
          $display("%0t: final_part mismatch, expected %b actual %b",
                   $realtime, want.second_half, dig_ch.final_part);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Message side. Inputs change on the falling edge; a request is taken at the
  // rising edge where valid and ready are both high. valid stays up between
  // back-to-back requests, so anything that pauses the sender lowers it first.
  // ---------------------------------------------------------------------------
  task automatic send_word(input word_t data, input logic [2:0] count, input logic last);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      msg_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    msg_ch.valid = 1'b1;
    msg_ch.data_word = data;
    msg_ch.byte_count = count;
    msg_ch.last_word = last;
    do @(posedge clk); while (!msg_ch.ready);
    predict_digest(data, count, last);
    words_sent++;
  endtask

  // A message of n_full middle words and one last word carrying tail_count bytes.
  // With noisy set, some middle words carry a short or oversized count.
  task automatic send_message(input int unsigned n_full, input logic [2:0] tail_count,
                              input bit noisy);
    logic [2:0] cnt;
    for (int unsigned i = 0; i < n_full; i++) begin
      cnt = (noisy && $urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : FULL_WORD;
      send_word($urandom, cnt, 1'b0);
    end
    send_word($urandom, tail_count, 1'b1);
  endtask

  task automatic wait_for_digests();
    @(negedge clk);
    msg_ch.valid = 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // The empty message: only padding and a zero length. The stray data bytes
  // beyond a zero count must not leak into the digest.
  task automatic test_empty_message();
    send_word(32'hffffffff, 3'd0, 1'b1);
    send_word(32'h00000000, 3'd0, 1'b1);
  endtask

  // One-word messages ending in one to three bytes, and counts above four on
  // the last word, which saturate to a full word.
  task automatic test_partial_tail();
    for (int n = 1; n <= 7; n++) begin
      if (n == 4) continue;
      send_word($urandom, 3'(n), 1'b1);
    end
  endtask

  // Counts other than four on middle words are ignored.
  task automatic test_short_count_middle();
    send_word(32'h00000000, 3'd0, 1'b0);
    send_word(32'hffffffff, 3'd1, 1'b0);
    send_word($urandom, 3'd2, 1'b0);
    send_word($urandom, 3'd3, 1'b0);
    send_word($urandom, 3'd5, 1'b0);
    send_word($urandom, 3'd6, 1'b0);
    send_word($urandom, 3'd7, 1'b0);
    send_word(32'hffffffff, FULL_WORD, 1'b1);
  endtask

  // The sender holds off until both halves of a digest are out, then starts
  // the next message.
  task automatic test_pause_for_digest();
    send_message(3, 3'd2, 1'b0);
    wait_for_digests();
    send_message(2, FULL_WORD, 1'b0);
  endtask

  // Tails that land at the end of a block: the padding byte at the last two
  // word slots forces an extra block for the length; a tail that fills the
  // block puts the padding at the start of a fresh one.
  task automatic test_block_boundaries();
    send_message(13, 3'd0, 1'b0);  // padding at slot 13, length just fits
    send_message(13, FULL_WORD, 1'b0);  // padding at slot 14
    send_message(14, 3'd1, 1'b0);  // padding at slot 14 with a data byte
    send_message(14, FULL_WORD, 1'b0);  // padding at slot 15
    send_message(15, 3'd3, 1'b0);  // padding at slot 15 with three data bytes
    send_message(15, FULL_WORD, 1'b0);  // block fills, padding opens the next one
  endtask

  // Random messages: mostly short, a share ending near a block edge, a few long
  // enough to span several blocks. Tail counts cover the whole 3-bit range.
  task automatic test_random_messages(input int target, input bit tx_idle, input bit rx_idle);
    int          start_count;
    int unsigned pick, len;
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    start_count = words_sent;
    while (words_sent - start_count < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(0, 18);
      else if (pick < 9) len = $urandom_range(12, 16);
      else len = $urandom_range(28, 47);
      send_message(len, 3'($urandom_range(0, 7)), 1'b1);
    end
  endtask

  initial begin
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.data_word = '0;
    msg_ch.byte_count = '0;
    msg_ch.last_word = 1'b0;
    restart_message();
    for (int i = 0; i < 16; i++) md5_block[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with idling on both sides.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_empty_message();
    test_partial_tail();
    test_short_count_middle();
    test_pause_for_digest();
    test_block_boundaries();

    // Random part, alternating which side idles; the tail end runs flat out.
    test_random_messages(100, 1'b1, 1'b1);
    test_random_messages(60, 1'b0, 1'b1);
    test_random_messages(60, 1'b1, 1'b0);
    test_random_messages(50, 1'b0, 1'b0);

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
